@@ hdl/distributed_mutex_request_arbiter_defines.svh @@
// ============================================================================
// Distributed mutex request arbiter - assertion macros
// Shared concurrent assertion forms for the checker.
// ============================================================================
`ifndef DISTRIBUTED_MUTEX_REQUEST_ARBITER_DEFINES_SVH
`define DISTRIBUTED_MUTEX_REQUEST_ARBITER_DEFINES_SVH

// Clocked assertion, masked while reset is asserted
`define DMRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define DMRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dmra_pkg.sv @@
// ============================================================================
// dmra_pkg
// Types, codes and defaults shared by the mutex request arbiter modules.
// ============================================================================
package dmra_pkg;

    // Default sizing
    localparam int DEF_MAX_PROCS = 16;
    localparam int DEF_TIME_BITS = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_CNT = 1'd1;

    // Reset values of the configuration registers
    localparam logic [3:0] OWN_ID_RST   = 4'd1;
    localparam logic [4:0] PROC_CNT_RST = 5'd16;

    // Message codes
    localparam logic [2:0] OP_LOCAL_REQ    = 3'd0;
    localparam logic [2:0] OP_RELEASE      = 3'd1;
    localparam logic [2:0] OP_REMOTE_REQ   = 3'd2;
    localparam logic [2:0] OP_REMOTE_REPLY = 3'd3;
    localparam logic [2:0] OP_REMOTE_DONE  = 3'd4;

    // Node modes
    localparam logic [1:0] NODE_FREE = 2'd0;
    localparam logic [1:0] NODE_WAIT = 2'd1;
    localparam logic [1:0] NODE_BUSY = 2'd2;

    // Input beat
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  src_id;
        logic [15:0] msg_time;
        logic [15:0] req_time;
    } item_t;

    // Result beat
    typedef struct packed {
        logic       send_reply;
        logic [3:0] reply_to;
        logic       entered;
        logic       all_done;
        logic [1:0] mutex_mode;
        logic       last;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rel_scan;
        logic scan_last;
    } dp_sts_t;

endpackage

@@ hdl/distributed_mutex_request_arbiter.sv @@
// The accepting edge loads the item; the result and its strobe are registered from execute.
// A release with k answerable deferred peers strobes k replies on consecutive cycles,
// the first comes in the cycle after other results would (the walker clears one mask
// bit per cycle). Busy holds through execute and the walk. Every other message gives one
// result; a new item is taken only once idle again. Results cannot be stalled. Async reset
// gives mode free, mask and counters clear, own_id 1, process_count 16.
// ============================================================================
// distributed_mutex_request_arbiter
// One node of Ricart-Agrawala mutual exclusion: request, defer and release.
// ============================================================================
module distributed_mutex_request_arbiter #(
    parameter int MAX_PROCS = dmra_pkg::DEF_MAX_PROCS,
    parameter int TIME_BITS = dmra_pkg::DEF_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dmra_pkg::item_t                 item,
    output dmra_pkg::result_t               result,
    output logic                            result_stb,
    input  logic                            cfg_we,
    input  logic [dmra_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [dmra_pkg::CFG_DATA_W-1:0] cfg_data
);

    dmra_pkg::ctl_cmd_t cmd;
    dmra_pkg::dp_sts_t  sts;

    // Sequencer
    dmra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Node state and message handling
    dmra_datapath #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .item       (item),
        .cmd        (cmd),
        .sts        (sts),
        .result     (result),
        .result_stb (result_stb)
    );

endmodule

@@ hdl/dmra_ctrl.sv @@
// ============================================================================
// dmra_ctrl
// Sequencer: accept, execute, then walk deferred replies on a release.
// ============================================================================
module dmra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dmra_pkg::dp_sts_t sts,
    output dmra_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t state_reg;
    logic   busy_reg;

    // State and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    if (sts.rel_scan)
                    begin
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (sts.scan_last)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Commands
    assign cmd.load = (state_reg == ST_IDLE) && start;
    assign cmd.exec = (state_reg == ST_EXEC);
    assign cmd.scan = (state_reg == ST_SCAN);
    assign busy     = busy_reg;

endmodule

@@ hdl/dmra_datapath.sv @@
// ============================================================================
// dmra_datapath
// Node state, config registers, message handling and the reply walker.
// ============================================================================
module dmra_datapath #(
    parameter int MAX_PROCS = dmra_pkg::DEF_MAX_PROCS,
    parameter int TIME_BITS = dmra_pkg::DEF_TIME_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dmra_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [dmra_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  dmra_pkg::item_t                   item,
    input  dmra_pkg::ctl_cmd_t                cmd,
    output dmra_pkg::dp_sts_t                 sts,
    output dmra_pkg::result_t                 result,
    output logic                              result_stb
);

    localparam int CW = $clog2(MAX_PROCS);
    localparam int PW = CW + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS - 1);

    // Config and node state
    logic [3:0]           own_id_reg;
    logic [4:0]           proc_cnt_reg;
    logic [1:0]           node_mode_reg, node_mode_next;
    logic [TIME_BITS-1:0] own_time_reg, own_time_next;
    logic [MAX_PROCS-1:0] deferred_reg, deferred_next;
    logic [CW-1:0]        reply_cnt_reg, reply_cnt_next;
    logic [CW-1:0]        done_cnt_reg, done_cnt_next;

    // Payload registers
    dmra_pkg::item_t      item_reg;
    logic [MAX_PROCS-1:0] scan_reg, scan_next;
    dmra_pkg::result_t    result_reg, result_next;
    logic                 result_stb_reg, result_stb_next;

    // Derived values
    logic [PW-1:0]        pc_eff;
    logic [CW-1:0]        needed;
    logic [MAX_PROCS-1:0] rng_mask, pend, src_hit, scan_clr;
    logic                 src_out, wait_win, answer, entered;
    logic [TIME_BITS-1:0] mtime, rtime;
    logic [CW-1:0]        rc_bump, dc_bump, low_idx;

    // Effective process count and peers needed
    always_comb
    begin
        if (int'(proc_cnt_reg) > MAX_PROCS)
            pc_eff = PW'(MAX_PROCS);
        else
            pc_eff = PW'(proc_cnt_reg);
        if (pc_eff >= PW'(2))
            needed = CW'(pc_eff - PW'(2));
        else
            needed = '0;
    end

    // Answerable id range, sender decode, lowest pending id
    always_comb
    begin
        low_idx = '0;
        for (int j = 0; j < MAX_PROCS; j++)
        begin
            rng_mask[j] = (j != 0) && (PW'(j) < pc_eff);
            src_hit[j]  = (int'(item_reg.src_id) == j);
        end
        for (int j = MAX_PROCS - 1; j >= 0; j--)
        begin
            if (scan_reg[j])
                low_idx = CW'(j);
        end
    end

    assign pend     = deferred_reg & rng_mask;
    assign scan_clr = scan_reg & (scan_reg - MAX_PROCS'(1));
    assign src_out  = int'(item_reg.src_id) >= MAX_PROCS;
    assign mtime    = TIME_BITS'(item_reg.msg_time);
    assign rtime    = TIME_BITS'(item_reg.req_time);
    assign wait_win = (own_time_reg > mtime) ||
                      ((own_time_reg == mtime) && (own_id_reg > item_reg.src_id));
    assign rc_bump  = (reply_cnt_reg != CNT_MAX) ? reply_cnt_reg + CW'(1) : reply_cnt_reg;
    assign dc_bump  = (done_cnt_reg != CNT_MAX) ? done_cnt_reg + CW'(1) : done_cnt_reg;

    // Tie-break for a remote request
    always_comb
    begin
        if (src_out)
            answer = 1'b1;
        else if (node_mode_reg == dmra_pkg::NODE_WAIT)
            answer = wait_win;
        else
            answer = (node_mode_reg != dmra_pkg::NODE_BUSY);
    end

    // Message handling and reply walk
    always_comb
    begin
        node_mode_next  = node_mode_reg;
        own_time_next   = own_time_reg;
        deferred_next   = deferred_reg;
        reply_cnt_next  = reply_cnt_reg;
        done_cnt_next   = done_cnt_reg;
        scan_next       = scan_reg;
        result_next     = result_reg;
        result_stb_next = 1'b0;
        entered         = 1'b0;

        if (cmd.exec)
        begin
            result_next = '0;
            case (item_reg.mode)
                dmra_pkg::OP_LOCAL_REQ:
                begin
                    own_time_next  = rtime;
                    reply_cnt_next = '0;
                    if (needed == '0)
                    begin
                        node_mode_next = dmra_pkg::NODE_BUSY;
                        entered        = 1'b1;
                    end
                    else
                    begin
                        node_mode_next = dmra_pkg::NODE_WAIT;
                    end
                end
                dmra_pkg::OP_RELEASE:
                begin
                    deferred_next  = '0;
                    node_mode_next = dmra_pkg::NODE_FREE;
                    scan_next      = pend;
                end
                dmra_pkg::OP_REMOTE_REQ:
                begin
                    if (!answer)
                        deferred_next = deferred_reg | src_hit;
                    result_next.send_reply = answer;
                    result_next.reply_to   = answer ? item_reg.src_id : 4'd0;
                end
                dmra_pkg::OP_REMOTE_REPLY:
                begin
                    reply_cnt_next = rc_bump;
                    if ((node_mode_reg == dmra_pkg::NODE_WAIT) && (rc_bump >= needed))
                    begin
                        node_mode_next = dmra_pkg::NODE_BUSY;
                        entered        = 1'b1;
                    end
                end
                dmra_pkg::OP_REMOTE_DONE:
                begin
                    done_cnt_next = dc_bump;
                end
                default:
                begin
                end
            endcase
            result_next.entered    = entered;
            result_next.all_done   = (done_cnt_next >= needed);
            result_next.mutex_mode = node_mode_next;
            result_next.last       = 1'b1;
            // a release with pending replies reports from the walker instead
            result_stb_next = !sts.rel_scan;
        end
        else if (cmd.scan)
        begin
            result_next.send_reply = 1'b1;
            result_next.reply_to   = 4'(low_idx);
            result_next.entered    = 1'b0;
            result_next.all_done   = (done_cnt_reg >= needed);
            result_next.mutex_mode = node_mode_reg;
            result_next.last       = (scan_clr == '0);
            result_stb_next        = 1'b1;
            scan_next              = scan_clr;
        end
    end

    // Control state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg     <= dmra_pkg::OWN_ID_RST;
            proc_cnt_reg   <= dmra_pkg::PROC_CNT_RST;
            node_mode_reg  <= dmra_pkg::NODE_FREE;
            own_time_reg   <= '0;
            deferred_reg   <= '0;
            reply_cnt_reg  <= '0;
            done_cnt_reg   <= '0;
            result_stb_reg <= 1'b0;
        end
        else
        begin
            node_mode_reg  <= node_mode_next;
            own_time_reg   <= own_time_next;
            deferred_reg   <= deferred_next;
            reply_cnt_reg  <= reply_cnt_next;
            done_cnt_reg   <= done_cnt_next;
            result_stb_reg <= result_stb_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    dmra_pkg::CFG_OWN_ID:   own_id_reg   <= cfg_data[3:0];
                    dmra_pkg::CFG_PROC_CNT: proc_cnt_reg <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        scan_reg   <= scan_next;
        result_reg <= result_next;
    end

    assign sts.rel_scan  = (item_reg.mode == dmra_pkg::OP_RELEASE) && (pend != '0);
    assign sts.scan_last = (scan_clr == '0);
    assign result        = result_reg;
    assign result_stb    = result_stb_reg;

endmodule

@@ hdl/dmra_checker.sv @@
// ============================================================================
// dmra_checker
// Port-level checks on the arbiter's sequencing and result beats.
// ============================================================================
`include "distributed_mutex_request_arbiter_defines.svh"

module dmra_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input dmra_pkg::result_t result,
    input logic              result_stb
);

    // An accepted item keeps the node busy for its execute cycle
    `DMRA_ASSERT(a_accept_busy, start && !busy |=> busy, "accept did not raise busy")

    // Release replies come out back to back until the last beat
    `DMRA_ASSERT(a_walk_cont, result_stb && !result.last |=> result_stb, "reply walk gap")

    // A non-final beat only occurs while the walker still holds the node busy
    `DMRA_ASSERT(a_walk_busy, result_stb && !result.last |-> busy && result.send_reply,
        "non-final beat outside reply walk")

    // Granting the critical section reports the critical mode
    `DMRA_ASSERT(a_enter_mode, result_stb && result.entered |->
        result.mutex_mode == dmra_pkg::NODE_BUSY, "grant without critical mode")

    // No strobe while reset is held
    `DMRA_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !result_stb, "strobe during reset")

endmodule

bind distributed_mutex_request_arbiter dmra_checker u_dmra_checker (.*);

@@ bench/distributed_mutex_request_arbiter_test.sv @@
// ============================================================================
// distributed_mutex_request_arbiter_test
// Self-checking bench for one Ricart-Agrawala node. A short directed plan
// covers the corner cases at fixed register settings. Random request,
// reply, defer and release episodes follow, mixed with noise messages, over
// several own_id / process_count settings. Every result beat is checked
// against an in-bench model of the node or the plan's expected beat.
// ============================================================================
module distributed_mutex_request_arbiter_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int COUNT_TOP      = dmra_pkg::DEF_MAX_PROCS - 1;

    // Codes 5..7 carry no message; the node must ignore them
    localparam logic [2:0] OP_UNKNOWN = 3'd7;

    typedef enum logic { ROW_BEAT, ROW_SETTINGS } row_kind_t;

    // One line of the directed plan
    typedef struct packed {
        row_kind_t         kind;
        dmra_pkg::item_t   beat;
        logic              typed;
        dmra_pkg::result_t want;
        logic [4:0]        cfg_own;
        logic [4:0]        cfg_procs;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic start = 1'b0;
    logic busy;
    dmra_pkg::item_t cmd_beat = '0;
    dmra_pkg::result_t res_beat;
    logic result_stb;
    logic cfg_we = 1'b0;
    logic [dmra_pkg::CFG_IDX_W-1:0] cfg_idx = dmra_pkg::CFG_OWN_ID;
    logic [dmra_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Node model state and its copy of the registers
    logic [1:0] node_state = dmra_pkg::NODE_FREE;
    logic [15:0] own_stamp = '0;
    logic [15:0] deferred = '0;
    logic [3:0] reply_cnt = '0;
    logic [3:0] done_cnt = '0;
    logic [3:0] my_id = dmra_pkg::OWN_ID_RST;
    logic [4:0] proc_total = dmra_pkg::PROC_CNT_RST;

    dmra_pkg::result_t step_out[$];
    dmra_pkg::result_t due_results[$];
    dmra_pkg::result_t oldest;
    plan_row_t plan[$];

    int mismatches = 0;
    int beats_accepted = 0;
    int results_seen = 0;
    int grants_seen = 0;
    int replies_seen = 0;
    int settings_count = 0;
    bit steady = 1'b0;

    distributed_mutex_request_arbiter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (cmd_beat),
        .result     (res_beat),
        .result_stb (result_stb),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Node model
    // ------------------------------------------------------------------
    function automatic int peers_needed();
        int span;
        span = (proc_total > dmra_pkg::DEF_MAX_PROCS) ? dmra_pkg::DEF_MAX_PROCS
                                                      : int'(proc_total);
        return (span >= 2) ? span - 2 : 0;
    endfunction

    function automatic dmra_pkg::result_t pack_result(logic send, logic [3:0] to,
                                                      logic ent, logic fin);
        dmra_pkg::result_t r;
        r.send_reply = send;
        r.reply_to   = to;
        r.entered    = ent;
        r.all_done   = (int'(done_cnt) >= peers_needed());
        r.mutex_mode = node_state;
        r.last       = fin;
        return r;
    endfunction

    // Apply one message to the node and collect the result beats it causes
    task automatic node_step(input dmra_pkg::item_t it);
        int span;
        logic [15:0] pend;
        logic answer;
        logic ent;
        step_out.delete();
        ent = 1'b0;
        span = (proc_total > dmra_pkg::DEF_MAX_PROCS) ? dmra_pkg::DEF_MAX_PROCS
                                                      : int'(proc_total);
        case (it.mode)
            dmra_pkg::OP_LOCAL_REQ:
            begin
                own_stamp  = it.req_time;
                reply_cnt  = '0;
                node_state = dmra_pkg::NODE_WAIT;
                if (peers_needed() == 0)
                begin
                    node_state = dmra_pkg::NODE_BUSY;
                    ent = 1'b1;
                end
                step_out.push_back(pack_result(1'b0, 4'd0, ent, 1'b1));
            end
            dmra_pkg::OP_RELEASE:
            begin
                pend = deferred;
                deferred = '0;
                node_state = dmra_pkg::NODE_FREE;
                // only ids 1 .. span-1 get a reply; the rest are dropped
                for (int i = 1; i < span; i++)
                    if (pend[i])
                        step_out.push_back(pack_result(1'b1, 4'(i), 1'b0, 1'b0));
                if (step_out.size() == 0)
                    step_out.push_back(pack_result(1'b0, 4'd0, 1'b0, 1'b1));
                else
                    step_out[step_out.size()-1].last = 1'b1;
            end
            dmra_pkg::OP_REMOTE_REQ:
            begin
                if (node_state == dmra_pkg::NODE_WAIT)
                    answer = (own_stamp > it.msg_time) ||
                             (own_stamp == it.msg_time && my_id > it.src_id);
                else
                    answer = (node_state != dmra_pkg::NODE_BUSY);
                if (!answer)
                    deferred[it.src_id] = 1'b1;
                step_out.push_back(pack_result(answer, answer ? it.src_id : 4'd0,
                                               1'b0, 1'b1));
            end
            dmra_pkg::OP_REMOTE_REPLY:
            begin
                if (reply_cnt != 4'(COUNT_TOP))
                    reply_cnt = reply_cnt + 4'd1;
                if (node_state == dmra_pkg::NODE_WAIT && int'(reply_cnt) >= peers_needed())
                begin
                    node_state = dmra_pkg::NODE_BUSY;
                    ent = 1'b1;
                end
                step_out.push_back(pack_result(1'b0, 4'd0, ent, 1'b1));
            end
            default:
            begin
                if (it.mode == dmra_pkg::OP_REMOTE_DONE && done_cnt != 4'(COUNT_TOP))
                    done_cnt = done_cnt + 4'd1;
                step_out.push_back(pack_result(1'b0, 4'd0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    function automatic int idle_gap();
        int n;
        n = 0;
        if (steady)
            return 0;
        while (n < 6 && $urandom_range(0, 99) < 37)
            n++;
        return n;
    endfunction

    function automatic dmra_pkg::item_t make_beat(logic [2:0] md, logic [3:0] src,
                                                  logic [15:0] mt, logic [15:0] rt);
        dmra_pkg::item_t it;
        it.mode     = md;
        it.src_id   = src;
        it.msg_time = mt;
        it.req_time = rt;
        return it;
    endfunction

    // Offer one beat and wait for it to be taken; returns on the accepting edge
    // with start still high, so the caller decides the next cycle.
    task automatic send_beat(input dmra_pkg::item_t it, input bit typed,
                             input dmra_pkg::result_t want);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd_beat <= it;
        do
            @(posedge clk);
        while (busy);
        node_step(it);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_out[k])
                due_results.push_back(step_out[k]);
        beats_accepted++;
    endtask

    task automatic send_checked(input dmra_pkg::item_t it);
        send_beat(it, 1'b0, '0);
    endtask

    // Hold off the sender until every expected result beat has come
    task automatic drain_results();
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Both registers, on back-to-back edges, with the node idle
    task automatic write_settings(input logic [4:0] own, input logic [4:0] procs);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= dmra_pkg::CFG_OWN_ID;
        cfg_data <= own;
        @(posedge clk);
        cfg_idx  <= dmra_pkg::CFG_PROC_CNT;
        cfg_data <= procs;
        @(posedge clk);
        cfg_we <= 1'b0;
        my_id = own[3:0];
        proc_total = procs;
        settings_count++;
    endtask

    // Noise now and then: any code, any fields
    task automatic send_with_noise(input dmra_pkg::item_t it);
        if ($urandom_range(0, 99) < 8)
            send_checked(make_beat(3'($urandom_range(0, 7)), 4'($urandom),
                                   16'($urandom), 16'($urandom)));
        send_checked(it);
    endtask

    function automatic logic [15:0] rival_stamp();
        if ($urandom_range(0, 99) < 30)
            return 16'($urandom);
        return own_stamp + 16'($urandom_range(0, 4)) - 16'd2;
    endfunction

    // One request / reply / critical section / release round with random content
    task automatic run_episode();
        int nrep;
        logic [15:0] rt;
        rt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        send_with_noise(make_beat(dmra_pkg::OP_LOCAL_REQ, 4'($urandom), 16'($urandom), rt));
        nrep = peers_needed() + $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0)
            nrep = $urandom_range(0, peers_needed());
        for (int k = 0; k < nrep; k++)
        begin
            if ($urandom_range(0, 99) < 35)
                send_with_noise(make_beat(dmra_pkg::OP_REMOTE_REQ, 4'($urandom),
                                          rival_stamp(), 16'($urandom)));
            if ($urandom_range(0, 99) < 10)
                send_with_noise(make_beat(dmra_pkg::OP_REMOTE_DONE, 4'($urandom),
                                          16'($urandom), 16'($urandom)));
            send_with_noise(make_beat(dmra_pkg::OP_REMOTE_REPLY, 4'($urandom),
                                      16'($urandom), 16'($urandom)));
        end
        // requests arriving inside the critical section get deferred
        repeat ($urandom_range(0, 4))
            send_with_noise(make_beat(dmra_pkg::OP_REMOTE_REQ, 4'($urandom),
                                      16'($urandom), 16'($urandom)));
        send_with_noise(make_beat(dmra_pkg::OP_RELEASE, 4'($urandom), 16'($urandom),
                                  16'($urandom)));
    endtask

    task automatic run_phase(input logic [4:0] own, input logic [4:0] procs,
                             input int beats);
        int target;
        write_settings(own, procs);
        target = beats_accepted + beats;
        while (beats_accepted < target)
            run_episode();
    endtask

    // ------------------------------------------------------------------
    // Directed plan rows
    // ------------------------------------------------------------------
    function automatic plan_row_t beat_row(logic [2:0] md, logic [3:0] src,
                                           logic [15:0] mt, logic [15:0] rt);
        plan_row_t r;
        r = '0;
        r.kind = ROW_BEAT;
        r.beat = make_beat(md, src, mt, rt);
        return r;
    endfunction

    function automatic plan_row_t typed_row(logic [2:0] md, logic [3:0] src,
                                            logic [15:0] mt, logic [15:0] rt,
                                            logic send, logic [3:0] to, logic ent,
                                            logic fin_all, logic [1:0] node);
        plan_row_t r;
        r = beat_row(md, src, mt, rt);
        r.typed = 1'b1;
        r.want  = '{send_reply: send, reply_to: to, entered: ent,
                    all_done: fin_all, mutex_mode: node, last: 1'b1};
        return r;
    endfunction

    function automatic plan_row_t settings_row(logic [4:0] own, logic [4:0] procs);
        plan_row_t r;
        r = '0;
        r.kind      = ROW_SETTINGS;
        r.cfg_own   = own;
        r.cfg_procs = procs;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string show(dmra_pkg::result_t r);
        return $sformatf("{reply %0d to %0d, entered %0d, all_done %0d, mode %0d, last %0d}",
                         r.send_reply, r.reply_to, r.entered, r.all_done,
                         r.mutex_mode, r.last);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_stb)
        begin
            results_seen++;
            if (res_beat.entered === 1'b1)
                grants_seen++;
            if (res_beat.send_reply === 1'b1)
                replies_seen++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing expected: %s", show(res_beat));
            end
            else
            begin
                oldest = due_results.pop_front();
                if (res_beat !== oldest)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %s, got %s",
                                 show(oldest), show(res_beat));
                end
            end
        end
    end

    // Watchdog: cycles with no beat taken in either direction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_stb)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("distributed_mutex_request_arbiter regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;

        // at reset: own_id 1, 16 processes, 14 peers needed
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_DONE, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_FREE));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REPLY, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_FREE));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd15, 16'hFFFF, 16'h0000,
                                 1'b1, 4'd15, 1'b0, 1'b0, dmra_pkg::NODE_FREE));
        plan.push_back(typed_row(dmra_pkg::OP_RELEASE, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_FREE));
        plan.push_back(typed_row(OP_UNKNOWN, 4'd15, 16'hFFFF, 16'hFFFF,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_FREE));
        plan.push_back(typed_row(dmra_pkg::OP_LOCAL_REQ, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_WAIT));
        // equal stamps: id tie-break decides
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd0, 16'h0000, 16'h0000,
                                 1'b1, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_WAIT));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd2, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_WAIT));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd15, 16'hFFFF, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_WAIT));
        // new local request while already waiting
        plan.push_back(typed_row(dmra_pkg::OP_LOCAL_REQ, 4'd0, 16'h0000, 16'hFFFF,
                                 1'b0, 4'd0, 1'b0, 1'b0, dmra_pkg::NODE_WAIT));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd3, 16'h0000, 16'h0000,
                                 1'b1, 4'd3, 1'b0, 1'b0, dmra_pkg::NODE_WAIT));
        plan.push_back(beat_row(dmra_pkg::OP_RELEASE, 4'd0, 16'h0000, 16'h0000));
        // two processes: immediate grant, deferred ids out of reach
        plan.push_back(settings_row(5'd1, 5'd2));
        plan.push_back(typed_row(dmra_pkg::OP_LOCAL_REQ, 4'd0, 16'h0000, 16'h1234,
                                 1'b0, 4'd0, 1'b1, 1'b1, dmra_pkg::NODE_BUSY));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd4, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b1, dmra_pkg::NODE_BUSY));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REQ, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b1, dmra_pkg::NODE_BUSY));
        plan.push_back(typed_row(dmra_pkg::OP_RELEASE, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b1, dmra_pkg::NODE_FREE));
        // three processes: grant on the first reply
        plan.push_back(settings_row(5'd1, 5'd3));
        plan.push_back(typed_row(dmra_pkg::OP_LOCAL_REQ, 4'd0, 16'h0000, 16'h8000,
                                 1'b0, 4'd0, 1'b0, 1'b1, dmra_pkg::NODE_WAIT));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REPLY, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b1, 1'b1, dmra_pkg::NODE_BUSY));
        plan.push_back(typed_row(dmra_pkg::OP_REMOTE_REPLY, 4'd0, 16'h0000, 16'h0000,
                                 1'b0, 4'd0, 1'b0, 1'b1, dmra_pkg::NODE_BUSY));
        plan.push_back(beat_row(dmra_pkg::OP_REMOTE_REQ, 4'd1, 16'h0000, 16'h0000));
        plan.push_back(beat_row(dmra_pkg::OP_REMOTE_REQ, 4'd9, 16'hFFFF, 16'h0000));
        // count above the maximum is clamped; count below two needs no peers
        plan.push_back(settings_row(5'd0, 5'd31));
        plan.push_back(beat_row(dmra_pkg::OP_RELEASE, 4'd0, 16'h0000, 16'h0000));
        plan.push_back(settings_row(5'd15, 5'd0));
        plan.push_back(beat_row(dmra_pkg::OP_LOCAL_REQ, 4'd0, 16'h0000, 16'h0001));
        plan.push_back(beat_row(dmra_pkg::OP_RELEASE, 4'd0, 16'h0000, 16'h0000));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETTINGS)
                write_settings(plan[i].cfg_own, plan[i].cfg_procs);
            else
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // random episodes over a spread of settings
        run_phase(5'd15, 5'd16, 70);
        run_phase(5'd8, 5'd5, 40);
        run_phase(5'd0, 5'd1, 25);
        steady = 1'b1;
        run_phase(5'd17, 5'd31, 40);
        steady = 1'b0;
        run_phase(5'($urandom_range(1, 15)), 5'd2, 30);
        write_settings(5'($urandom_range(1, 15)), 5'($urandom_range(3, 16)));
        for (int n = 0; n < 2; n++)
        begin
            repeat (2) run_episode();
            drain_results();
        end
        run_phase(5'($urandom_range(1, 15)), 5'($urandom_range(3, 16)), 30);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d command beats and %0d result beats over %0d register settings",
                 beats_accepted, results_seen, settings_count);
        $display("  %0d critical section grants, %0d replies sent, %0d mismatches",
                 grants_seen, replies_seen, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("distributed_mutex_request_arbiter regression: pass");
        else
            $display("distributed_mutex_request_arbiter regression: fail");
        $finish;
    end

endmodule
